>>> rtl/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and constants for the framed relay command receiver.
// ----------------------------------------------------------------------------
package frc_pkg;

  // framing and payload characters
  localparam logic [7:0] START_MARK = 8'h3C;  // '<'
  localparam logic [7:0] END_MARK   = 8'h3E;  // '>'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_ONE   = 8'h31;  // '1'

  // output word layout
  localparam int unsigned TDATA_W = 16;
  localparam int unsigned PAD_W   = TDATA_W - 10;

  // accepted command, handed from parser to serializer
  typedef struct packed {
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic       relay1_on;
    logic       relay2_on;
  } reply_t;

  // position inside the echoed reply
  typedef enum logic [1:0] {
    BEAT_OPEN,
    BEAT_FIRST,
    BEAT_SECOND,
    BEAT_CLOSE
  } beat_e;

  // true for '0' or '1'
  function automatic logic is_bit_char(input logic [7:0] c);
    return (c == CHAR_ZERO) || (c == CHAR_ONE);
  endfunction

endpackage

>>> rtl/frc_parser.sv
// ----------------------------------------------------------------------------
// frc_parser
// Frame parser: tracks framing, counts payload, keeps the first two payload
// bytes, owns the relay state and registers one reply per matching frame.
// ----------------------------------------------------------------------------
module frc_parser #(
  parameter int unsigned BUFFER_CHARS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          byte_vld_i,
  input  logic [7:0]    byte_i,
  output logic          ready_o,
  input  logic          rep_take_i,
  output logic          rep_vld_o,
  output frc_pkg::reply_t rep_o
);
  import frc_pkg::*;

  localparam int unsigned CntW = $clog2(BUFFER_CHARS);
  localparam logic [CntW-1:0] CntMax = CntW'(BUFFER_CHARS - 1);

  logic            in_frame_q, in_frame_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      second_q, second_d;
  logic            relay1_q, relay1_d;
  logic            relay2_q, relay2_d;
  logic            rep_vld_q, rep_vld_d;
  reply_t          rep_q, rep_d;
  logic            accept;
  logic            match;

  // a new word fits when the reply slot is empty or drains this cycle
  assign ready_o = !rep_vld_q || rep_take_i;
  assign accept  = byte_vld_i && ready_o;

  assign match = (cnt_q == CntW'(2)) && is_bit_char(first_q) && is_bit_char(second_q);

  // frame tracking and reply generation
  always_comb begin
    in_frame_d = in_frame_q;
    cnt_d      = cnt_q;
    first_d    = first_q;
    second_d   = second_q;
    relay1_d   = relay1_q;
    relay2_d   = relay2_q;
    rep_vld_d  = rep_vld_q && !rep_take_i;
    rep_d      = rep_q;
    if (accept) begin
      if (!in_frame_q) begin
        if (byte_i == START_MARK) begin
          in_frame_d = 1'b1;
          cnt_d      = '0;
        end
      end else if (byte_i != END_MARK) begin
        if (cnt_q == CntW'(0)) begin
          first_d = byte_i;
        end else if (cnt_q == CntW'(1)) begin
          second_d = byte_i;
        end
        if (cnt_q < CntMax) begin
          cnt_d = cnt_q + CntW'(1);
        end
      end else begin
        in_frame_d = 1'b0;
        cnt_d      = '0;
        if (match) begin
          relay2_d              = (first_q == CHAR_ONE);
          relay1_d              = (second_q == CHAR_ONE);
          rep_vld_d             = 1'b1;
          rep_d.first_char      = first_q;
          rep_d.second_char     = second_q;
          rep_d.relay1_on       = (second_q == CHAR_ONE);
          rep_d.relay2_on       = (first_q == CHAR_ONE);
        end
      end
    end
  end

  // control and relay state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      cnt_q      <= '0;
      first_q    <= '0;
      second_q   <= '0;
      relay1_q   <= 1'b0;
      relay2_q   <= 1'b0;
      rep_vld_q  <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      cnt_q      <= cnt_d;
      first_q    <= first_d;
      second_q   <= second_d;
      relay1_q   <= relay1_d;
      relay2_q   <= relay2_d;
      rep_vld_q  <= rep_vld_d;
    end
  end

  // reply payload
  always_ff @(posedge clk_i) begin
    rep_q <= rep_d;
  end

  assign rep_vld_o = rep_vld_q;
  assign rep_o     = rep_q;

endmodule

>>> rtl/frc_serializer.sv
// ----------------------------------------------------------------------------
// frc_serializer
// Reply serializer: sends '<', c1, c2, '>' as four output words, the last
// one marked, with the relay drive of the command on every word.
// ----------------------------------------------------------------------------
module frc_serializer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rep_vld_i,
  input  frc_pkg::reply_t               rep_i,
  output logic                          rep_take_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [frc_pkg::TDATA_W-1:0]   m_tdata_o,
  output logic                          m_tlast_o
);
  import frc_pkg::*;

  logic   busy_q, busy_d;
  beat_e  beat_q, beat_d;
  reply_t rep_q;
  logic   last_hs;
  logic   take;
  logic [7:0] tx_byte;

  assign last_hs    = busy_q && m_tready_i && (beat_q == BEAT_CLOSE);
  assign take       = rep_vld_i && (!busy_q || last_hs);
  assign rep_take_o = take;

  // next beat
  always_comb begin
    busy_d = busy_q;
    beat_d = beat_q;
    if (take) begin
      busy_d = 1'b1;
      beat_d = BEAT_OPEN;
    end else if (busy_q && m_tready_i) begin
      case (beat_q)
        BEAT_OPEN:   beat_d = BEAT_FIRST;
        BEAT_FIRST:  beat_d = BEAT_SECOND;
        BEAT_SECOND: beat_d = BEAT_CLOSE;
        BEAT_CLOSE:  busy_d = 1'b0;
        default:     busy_d = 1'b0;
      endcase
    end
  end

  // output word for the current beat
  always_comb begin
    case (beat_q)
      BEAT_OPEN:   tx_byte = START_MARK;
      BEAT_FIRST:  tx_byte = rep_q.first_char;
      BEAT_SECOND: tx_byte = rep_q.second_char;
      BEAT_CLOSE:  tx_byte = END_MARK;
      default:     tx_byte = END_MARK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      beat_q <= BEAT_OPEN;
    end else begin
      busy_q <= busy_d;
      beat_q <= beat_d;
    end
  end

  // reply held for the duration of its four words
  always_ff @(posedge clk_i) begin
    if (take) begin
      rep_q <= rep_i;
    end
  end

  assign m_tvalid_o = busy_q;
  assign m_tlast_o  = (beat_q == BEAT_CLOSE);
  assign m_tdata_o  = {PAD_W'(0), rep_q.relay2_on, rep_q.relay1_on, tx_byte};

endmodule

>>> rtl/framed_relay_command_receiver_top.sv
// ----------------------------------------------------------------------------
// framed_relay_command_receiver_top
// Receives serial bytes, decodes "<xy>" relay commands and echoes them.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle. Bytes outside a '<' ... '>' frame are
// dropped; a frame whose payload is exactly two characters of '0'/'1' sets
// relay 2 from the first and relay 1 from the second and is echoed as four
// output words ('<', c1, c2, '>', tlast on the '>'), one per cycle while the
// sink is ready. The parser registers the command into a one-entry slot and
// the serializer drains it, so input bytes keep flowing during an echo; the
// input stalls only when a second command completes before the first echo
// has left, and then until its last word is taken. s_axis_tready follows
// m_axis_tready in the same cycle on that path.
module framed_relay_command_receiver_top #(
  parameter int unsigned BUFFER_CHARS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] tx_byte, [8] relay1_on, [9] relay2_on
  output logic        m_axis_tlast    // reply_last
);
  import frc_pkg::*;

  logic   rep_vld;
  logic   rep_take;
  reply_t rep;

  // frame parser and relay state
  frc_parser #(
    .BUFFER_CHARS(BUFFER_CHARS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (s_axis_tvalid),
    .byte_i     (s_axis_tdata),
    .ready_o    (s_axis_tready),
    .rep_take_i (rep_take),
    .rep_vld_o  (rep_vld),
    .rep_o      (rep)
  );

  // echo serializer
  frc_serializer u_serializer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rep_vld_i  (rep_vld),
    .rep_i      (rep),
    .rep_take_o (rep_take),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

>>> rtl/frc_checker.sv
// ----------------------------------------------------------------------------
// frc_checker
// Port-level checks on the echoed reply stream of the receiver.
// ----------------------------------------------------------------------------
module frc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import frc_pkg::*;

  // the marked word is always the closing marker
  a_last_is_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[7:0] == END_MARK))
    else $error("reply last word is not the closing marker");

  // a reply goes out without gaps until its last word
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("gap inside a reply");

  // relay bits stay the same across one reply
  a_relay_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> $stable(m_axis_tdata[9:8]))
    else $error("relay bits changed inside a reply");

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output word changed while stalled");

  // a reply after a finished one opens with the start marker
  a_open_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
      (!m_axis_tvalid || (m_axis_tdata[7:0] == START_MARK)))
    else $error("reply does not open with the start marker");

endmodule

bind framed_relay_command_receiver_top frc_checker u_frc_checker (.*);
